@@ sv/frac_pkg.sv @@
// ----------------------------------------------------------------------------
// frac_pkg: shared types and constants of the fraction reducer
// Operand width default and the back unit sequencer state type.
// ----------------------------------------------------------------------------
package frac_pkg;

   localparam int OPERAND_BITS_DEF = 31;

   // back unit sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_GCD,
      ST_DIV,
      ST_DONE
   } back_state_type;

endpackage

@@ sv/frac_if.sv @@
// ----------------------------------------------------------------------------
// frac_req_if / frac_rsp_if: valid/ready channels of the fraction reducer
// Request carries the two operands, response the reduced fraction.
// ----------------------------------------------------------------------------
interface frac_req_if #(parameter int OPERAND_BITS = 31);
   logic                    valid;
   logic                    ready;
   logic [OPERAND_BITS-1:0] numerator;
   logic [OPERAND_BITS-1:0] denominator;
   modport source (output valid, numerator, denominator, input ready);
   modport sink   (input valid, numerator, denominator, output ready);
endinterface

interface frac_rsp_if #(parameter int OPERAND_BITS = 31);
   logic                    valid;
   logic                    ready;
   logic [OPERAND_BITS-1:0] reduced_numerator;
   logic [OPERAND_BITS-1:0] reduced_denominator;
   logic [OPERAND_BITS-1:0] common_divisor;
   logic                    zero_operand;
   modport source (output valid, reduced_numerator, reduced_denominator,
                   common_divisor, zero_operand, input ready);
   modport sink   (input valid, reduced_numerator, reduced_denominator,
                   common_divisor, zero_operand, output ready);
endinterface

@@ sv/frac_front.sv @@
// ----------------------------------------------------------------------------
// frac_front: intake and classification
// Accept items into a two-entry queue, tagging those with a zero operand.
// ----------------------------------------------------------------------------
module frac_front #(
   parameter int OPERAND_BITS = frac_pkg::OPERAND_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  logic [OPERAND_BITS-1:0] in_num,
   input  logic [OPERAND_BITS-1:0] in_den,
   output logic                    q_valid,
   input  logic                    q_ready,
   output logic [OPERAND_BITS-1:0] q_num,
   output logic [OPERAND_BITS-1:0] q_den,
   output logic                    q_zero
);
   import frac_pkg::*;

   logic [OPERAND_BITS-1:0] num_ff [2];
   logic [OPERAND_BITS-1:0] den_ff [2];
   logic [1:0]              zero_ff;
   logic                    wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0]              count_ff, count_in;
   logic                    push, pop;

   assign in_ready = (count_ff != 2'd2);
   assign q_valid  = (count_ff != 2'd0);
   assign push     = in_valid && in_ready;
   assign pop      = q_valid && q_ready;
   assign q_num    = num_ff[rd_ptr_ff];
   assign q_den    = den_ff[rd_ptr_ff];
   assign q_zero   = zero_ff[rd_ptr_ff];

   // advance pointers and fill count
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // store item with its zero-operand class
   always_ff @(posedge clock) begin
      if (push) begin
         num_ff[wr_ptr_ff]  <= in_num;
         den_ff[wr_ptr_ff]  <= in_den;
         zero_ff[wr_ptr_ff] <= (in_num == '0) || (in_den == '0);
      end
   end
endmodule

@@ sv/frac_back.sv @@
// ----------------------------------------------------------------------------
// frac_back: reduction engine
// Binary GCD, one shift or subtract step a cycle, then two restoring
// divisions run side by side, one bit a cycle, and a result register toward
// the response channel.
// ----------------------------------------------------------------------------
module frac_back #(
   parameter int OPERAND_BITS = frac_pkg::OPERAND_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    q_valid,
   output logic                    q_ready,
   input  logic [OPERAND_BITS-1:0] q_num,
   input  logic [OPERAND_BITS-1:0] q_den,
   input  logic                    q_zero,
   output logic                    out_valid,
   input  logic                    out_ready,
   output logic [OPERAND_BITS-1:0] out_rnum,
   output logic [OPERAND_BITS-1:0] out_rden,
   output logic [OPERAND_BITS-1:0] out_gcd,
   output logic                    out_zero
);
   import frac_pkg::*;

   localparam int CNT_BITS = $clog2(OPERAND_BITS + 1);

   back_state_type          state_ff, state_in;
   logic [OPERAND_BITS-1:0] a_ff, a_in, b_ff, b_in;
   logic [OPERAND_BITS-1:0] num_ff, num_in, den_ff, den_in;
   logic [OPERAND_BITS-1:0] rn_ff, rn_in, rd_ff, rd_in;
   logic [OPERAND_BITS-1:0] qn_ff, qn_in, qd_ff, qd_in;
   logic                    zero_ff, zero_in;
   logic [CNT_BITS-1:0]     cnt_ff, cnt_in;
   logic [OPERAND_BITS:0]   trial_n, trial_d;

   assign out_valid = (state_ff == ST_DONE);
   assign out_rnum  = qn_ff;
   assign out_rden  = qd_ff;
   assign out_gcd   = a_ff;
   assign out_zero  = zero_ff;
   assign q_ready   = (state_ff == ST_IDLE);

   // shift remainders left by one quotient bit
   assign trial_n = {rn_ff, num_ff[OPERAND_BITS-1]};
   assign trial_d = {rd_ff, den_ff[OPERAND_BITS-1]};

   // sequence the gcd and division phases
   always_comb begin
      state_in = state_ff;
      a_in = a_ff; b_in = b_ff;
      num_in = num_ff; den_in = den_ff;
      rn_in = rn_ff; rd_in = rd_ff;
      qn_in = qn_ff; qd_in = qd_ff;
      zero_in = zero_ff;
      cnt_in = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               a_in = q_num; b_in = q_den;
               num_in = q_num; den_in = q_den;
               zero_in = q_zero;
               cnt_in = '0;
               if (q_zero) begin
                  a_in = '0; qn_in = '0; qd_in = '0;
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_GCD;
               end
            end
         end
         ST_GCD: begin
            // cnt holds the exponent of the power of two common to both operands
            if (a_ff == b_ff) begin
               a_in = a_ff << cnt_ff;
               rn_in = '0; rd_in = '0;
               cnt_in = CNT_BITS'(OPERAND_BITS);
               state_in = ST_DIV;
            end else if (!a_ff[0] && !b_ff[0]) begin
               a_in = a_ff >> 1;
               b_in = b_ff >> 1;
               cnt_in = cnt_ff + 1'b1;
            end else if (!a_ff[0]) begin
               a_in = a_ff >> 1;
            end else if (!b_ff[0]) begin
               b_in = b_ff >> 1;
            end else if (a_ff > b_ff) begin
               a_in = (a_ff - b_ff) >> 1;
            end else begin
               b_in = (b_ff - a_ff) >> 1;
            end
         end
         ST_DIV: begin
            num_in = num_ff << 1;
            den_in = den_ff << 1;
            if (trial_n >= {1'b0, a_ff}) begin
               rn_in = OPERAND_BITS'(trial_n - {1'b0, a_ff});
               qn_in = {qn_ff[OPERAND_BITS-2:0], 1'b1};
            end else begin
               rn_in = trial_n[OPERAND_BITS-1:0];
               qn_in = {qn_ff[OPERAND_BITS-2:0], 1'b0};
            end
            if (trial_d >= {1'b0, a_ff}) begin
               rd_in = OPERAND_BITS'(trial_d - {1'b0, a_ff});
               qd_in = {qd_ff[OPERAND_BITS-2:0], 1'b1};
            end else begin
               rd_in = trial_d[OPERAND_BITS-1:0];
               qd_in = {qd_ff[OPERAND_BITS-2:0], 1'b0};
            end
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == CNT_BITS'(1)) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in; b_ff <= b_in;
      num_ff <= num_in; den_ff <= den_in;
      rn_ff <= rn_in; rd_ff <= rd_in;
      qn_ff <= qn_in; qd_ff <= qd_in;
      zero_ff <= zero_in;
      cnt_ff <= cnt_in;
   end
endmodule

@@ sv/fraction_reducer.sv @@
// Path: an item is registered in the queue; the engine runs the binary GCD
// shift or subtract steps, then divides both operands by the GCD one quotient
// bit at a time, and registers the result out. A zero operand skips both.
// One item at a time in the engine sets throughput; a two-item queue lets
// intake continue while the engine works.
// Reset (synchronous) empties the queue and idles the engine.
// ----------------------------------------------------------------------------
// fraction_reducer: reduce a fraction to lowest terms
// Front queue classifies items; back engine finds gcd and divides.
// ----------------------------------------------------------------------------
module fraction_reducer #(
   parameter int OPERAND_BITS = frac_pkg::OPERAND_BITS_DEF
) (
   input logic         clock,
   input logic         reset,
   frac_req_if.sink    req,
   frac_rsp_if.source  rsp
);
   import frac_pkg::*;

   logic                    q_valid, q_ready, q_zero;
   logic [OPERAND_BITS-1:0] q_num, q_den;

   // accept and queue items
   frac_front #(.OPERAND_BITS(OPERAND_BITS)) u_front (
      .clock, .reset,
      .in_valid(req.valid), .in_ready(req.ready),
      .in_num(req.numerator), .in_den(req.denominator),
      .q_valid, .q_ready, .q_num, .q_den, .q_zero
   );

   // reduce and deliver
   frac_back #(.OPERAND_BITS(OPERAND_BITS)) u_back (
      .clock, .reset,
      .q_valid, .q_ready, .q_num, .q_den, .q_zero,
      .out_valid(rsp.valid), .out_ready(rsp.ready),
      .out_rnum(rsp.reduced_numerator), .out_rden(rsp.reduced_denominator),
      .out_gcd(rsp.common_divisor), .out_zero(rsp.zero_operand)
   );
endmodule
